/* rtl/lofw_pkg.sv */
// Package for the line offset Fenwick tree block: action codes, item
// payload types and the controller state encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lofw_pkg;

	localparam int ACTION_W = 2;
	localparam int LINE_W = 10;
	localparam int FIELD_W = 32;
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOCATE = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [LINE_W-1:0] line_index;
		logic [FIELD_W-1:0] amount;
		logic [FIELD_W-1:0] position;
	} lofw_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] line_start;
		logic [LINE_W-1:0] found_line;
		logic [FIELD_W-1:0] column;
		logic bad_index;
	} lofw_rsp_t;

	typedef logic [COUNT_W-1:0] lofw_cfg_t;

	typedef enum logic [4:0] {
		ST_CLR = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_SEL = 5'b00100,
		ST_EX = 5'b01000,
		ST_FIN = 5'b10000
	} lofw_state_t;

endpackage
`default_nettype wire

/* rtl/lofw_if.sv */
// Valid/ready channel carrying one payload item per handshake.
// The payload type is set per instance; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface lofw_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lofw_mem.sv */
// Single-port synchronous memory holding the tree nodes.
// Registered read data, one access per cycle; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module lofw_mem #(
	parameter int DEPTH = 1024,
	parameter int AW = 10,
	parameter int DW = 32
) (
	input wire logic clk,
	input wire logic rd_en,
	input wire logic wr_en,
	input wire logic [AW-1:0] addr,
	input wire logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* rtl/lofw_ctrl.sv */
// Tree walker: takes an item, steps through tree nodes with a read and, in
// the next cycle, the update or compare, and holds the result item.
// Uses lofw_pkg and the lofw_if channel interface.
`timescale 1ns / 1ps
`default_nettype none
module lofw_ctrl #(
	parameter int DEPTH = 1024,
	parameter int OFFSET_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [((($clog2(DEPTH) + 1) > 12) ? ($clog2(DEPTH) + 1) : 12)-1:0] cnt,
	lofw_if.sink req,
	lofw_if.source rsp,
	output logic mem_rd,
	output logic mem_wr,
	output logic [$clog2(DEPTH)-1:0] mem_addr,
	output logic [OFFSET_BITS-1:0] mem_wdata,
	input wire logic [OFFSET_BITS-1:0] mem_rdata
);
	import lofw_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int KW = ((AW + 1) > 12) ? (AW + 1) : 12;

	lofw_state_t state_q;
	logic [AW-1:0] clr_q;
	logic out_valid_q;
	lofw_rsp_t out_q;

	logic [ACTION_W-1:0] act_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] line_q;
	logic [KW-1:0] step_q;
	logic [OFFSET_BITS-1:0] amt_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] sum_q;
	logic bad_q;

	logic accept;
	logic [KW-1:0] idx;
	logic idx_bad;
	logic [KW-1:0] step_init;
	logic [KW-1:0] low_bit;
	logic [KW-1:0] probe;
	logic probe_ok;
	logic sel_go;
	logic sel_done;
	logic out_free;
	logic [OFFSET_BITS-1:0] loc_sum;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign idx = KW'(req.data.line_index);
	assign idx_bad = (req.data.action == ACT_ADD || req.data.action == ACT_QUERY) &&
		(idx >= cnt);
	assign low_bit = k_q & (~k_q + KW'(1));
	assign probe = line_q + step_q;
	assign probe_ok = (probe < cnt);
	assign loc_sum = sum_q + mem_rdata;
	assign out_free = !out_valid_q || rsp.ready;

	// Highest power of two that does not exceed the count.
	always_comb begin
		step_init = '0;
		for (int i = 0; i < KW; i++) begin
			if (cnt[i]) begin
				step_init = KW'(1) << i;
			end
		end
	end

	// Decide whether the walk reads another node or is finished.
	always_comb begin
		sel_go = 1'b0;
		sel_done = 1'b0;
		if (bad_q) begin
			sel_done = 1'b1;
		end else begin
			case (act_q)
				ACT_ADD: begin
					sel_go = (k_q < cnt);
					sel_done = !sel_go;
				end
				ACT_QUERY: begin
					sel_go = (k_q != '0);
					sel_done = !sel_go;
				end
				ACT_LOCATE: begin
					sel_go = (step_q != '0) && probe_ok;
					sel_done = (step_q == '0);
				end
				default: begin
					sel_done = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		mem_rd = 1'b0;
		mem_wr = 1'b0;
		mem_addr = k_q[AW-1:0];
		mem_wdata = mem_rdata + amt_q;
		case (state_q)
			ST_CLR: begin
				mem_wr = 1'b1;
				mem_addr = clr_q;
				mem_wdata = '0;
			end
			ST_SEL: begin
				mem_rd = sel_go;
				mem_addr = (act_q == ACT_LOCATE) ? probe[AW-1:0] : k_q[AW-1:0];
			end
			ST_EX: begin
				mem_wr = (act_q == ACT_ADD);
			end
			default: begin
				mem_rd = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (sel_go) begin
						state_q <= ST_EX;
					end else if (sel_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_EX: begin
					state_q <= ST_SEL;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					act_q <= req.data.action;
					amt_q <= OFFSET_BITS'(req.data.amount);
					pos_q <= OFFSET_BITS'(req.data.position);
					sum_q <= '0;
					line_q <= '0;
					step_q <= step_init;
					bad_q <= idx_bad;
					k_q <= (req.data.action == ACT_ADD) ? idx + KW'(1) : idx;
				end
			end
			ST_SEL: begin
				// A locate step whose node lies past the count is skipped.
				if (act_q == ACT_LOCATE && !sel_go && !sel_done) begin
					step_q <= step_q >> 1;
				end
			end
			ST_EX: begin
				case (act_q)
					ACT_ADD: begin
						k_q <= k_q + low_bit;
					end
					ACT_QUERY: begin
						sum_q <= sum_q + mem_rdata;
						k_q <= k_q - low_bit;
					end
					ACT_LOCATE: begin
						if (loc_sum <= pos_q) begin
							sum_q <= loc_sum;
							line_q <= probe;
						end
						step_q <= step_q >> 1;
					end
					default: begin
						k_q <= k_q;
					end
				endcase
			end
			ST_FIN: begin
				if (out_free) begin
					out_q.line_start <= (act_q == ACT_QUERY && !bad_q) ?
						FIELD_W'(sum_q) : '0;
					out_q.found_line <= (act_q == ACT_LOCATE) ? line_q[LINE_W-1:0] : '0;
					out_q.column <= (act_q == ACT_LOCATE) ?
						FIELD_W'(pos_q - sum_q) : '0;
					out_q.bad_index <= bad_q;
				end
			end
			default: begin
				bad_q <= bad_q;
			end
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;
endmodule
`default_nettype wire

/* rtl/line_offset_fenwick_tree_core.sv */
// Top level of the line offset Fenwick tree: line count register, tree
// walker and node memory. Uses lofw_pkg, lofw_if, lofw_ctrl and lofw_mem.
//
//   channel   dir   payload       handshake
//   req       in    lofw_req_t    valid/ready, taken only when the walker is idle
//   rsp       out   lofw_rsp_t    valid/ready, one registered item per request
//   cfg       in    lofw_cfg_t    valid/ready, ready always high
//
// After reset the block clears every node memory word before it takes the
// first item; configuration writes are taken during that pass.
// Each tree node is a read on the single memory port, then an update or
// compare; a locate step past the count is skipped without a memory access.
// The walker takes the next item only once the current one has finished.
// A held result does not stop the next item; only its finish waits for it.
`timescale 1ns / 1ps
`default_nettype none
module line_offset_fenwick_tree_core #(
	parameter int DEPTH = 1024,
	parameter int OFFSET_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	lofw_if.sink req,
	lofw_if.source rsp,
	lofw_if.sink cfg
);
	import lofw_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int KW = ((AW + 1) > 12) ? (AW + 1) : 12;

	logic [COUNT_W-1:0] line_count_q;
	logic [KW-1:0] cnt_raw;
	logic [KW-1:0] cnt;
	logic mem_rd;
	logic mem_wr;
	logic [AW-1:0] mem_addr;
	logic [OFFSET_BITS-1:0] mem_wdata;
	logic [OFFSET_BITS-1:0] mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= COUNT_RESET;
		end else if (cfg.valid) begin
			line_count_q <= cfg.data;
		end
	end

	// The count in use never exceeds the tree depth.
	assign cnt_raw = KW'(line_count_q);
	assign cnt = (cnt_raw > KW'(DEPTH)) ? KW'(DEPTH) : cnt_raw;

	lofw_ctrl #(
		.DEPTH(DEPTH),
		.OFFSET_BITS(OFFSET_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cnt(cnt),
		.req(req),
		.rsp(rsp),
		.mem_rd(mem_rd),
		.mem_wr(mem_wr),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	lofw_mem #(
		.DEPTH(DEPTH),
		.AW(AW),
		.DW(OFFSET_BITS)
	) u_mem (
		.clk(clk),
		.rd_en(mem_rd),
		.wr_en(mem_wr),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);
endmodule
`default_nettype wire

/* rtl/lofw_checker.sv */
// Port-level checks for the line offset Fenwick tree top level, bound in.
// Uses lofw_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
module lofw_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire lofw_pkg::lofw_rsp_t rsp_data
);
	import lofw_pkg::*;

	// A result item that is held back keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result item changed while stalled");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in progress");

	// A rejected index gives no line start and no locate fields.
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.bad_index |->
			rsp_data.line_start == '0 && rsp_data.found_line == '0 &&
			rsp_data.column == '0)
		else $error("bad index item carries data");

	// Query and locate fields never appear together.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.line_start != '0 |->
			rsp_data.found_line == '0 && rsp_data.column == '0)
		else $error("query and locate fields both set");
endmodule

bind line_offset_fenwick_tree_core lofw_checker u_lofw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data(rsp.data)
);
`default_nettype wire
